/* src/spq_pkg.sv */
package spq_pkg;

	localparam logic [1:0] KIND_INSERT = 2'd0;
	localparam logic [1:0] KIND_PEEK   = 2'd1;
	localparam logic [1:0] KIND_REMOVE = 2'd2;

	localparam logic [1:0] ST_OK    = 2'd0;
	localparam logic [1:0] ST_EMPTY = 2'd1;
	localparam logic [1:0] ST_FULL  = 2'd2;

	// Command broadcast to every cell of the chain
	typedef struct packed {
		logic ins;
		logic rem;
	} cell_ctl_t;

endpackage

/* src/spq_cell.sv */
module spq_cell
	import spq_pkg::*;
#(
	parameter int PRIORITY_BITS = 8,
	parameter int KEY_BITS = 16
) (
	input  logic                     clk,
	input  logic                     arst_n,
	input  cell_ctl_t                ctl,
	input  logic [PRIORITY_BITS-1:0] new_prio,
	input  logic [KEY_BITS-1:0]      new_key,
	input  logic                     left_keep,
	input  logic                     left_valid,
	input  logic [PRIORITY_BITS-1:0] left_prio,
	input  logic [KEY_BITS-1:0]      left_key,
	input  logic                     right_valid,
	input  logic [PRIORITY_BITS-1:0] right_prio,
	input  logic [KEY_BITS-1:0]      right_key,
	output logic                     keep,
	output logic                     valid,
	output logic [PRIORITY_BITS-1:0] prio,
	output logic [KEY_BITS-1:0]      key
);

	logic                     valid_q;
	logic [PRIORITY_BITS-1:0] prio_q;
	logic [KEY_BITS-1:0]      key_q;
	logic                     valid_d;
	logic [PRIORITY_BITS-1:0] prio_d;
	logic [KEY_BITS-1:0]      key_d;

	// Hold the entry when it goes ahead of the new item (ties keep arrival order)
	assign keep = valid_q && (prio_q <= new_prio);

	always_comb begin
		valid_d = valid_q;
		prio_d  = prio_q;
		key_d   = key_q;
		if (ctl.ins && !keep) begin
			if (left_keep) begin
				valid_d = 1'b1;
				prio_d  = new_prio;
				key_d   = new_key;
			end else begin
				valid_d = left_valid;
				prio_d  = left_prio;
				key_d   = left_key;
			end
		end else if (ctl.rem) begin
			valid_d = right_valid;
			prio_d  = right_prio;
			key_d   = right_key;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else begin
			valid_q <= valid_d;
		end
	end

	always_ff @(posedge clk) begin
		prio_q <= prio_d;
		key_q  <= key_d;
	end

	assign valid = valid_q;
	assign prio  = prio_q;
	assign key   = key_q;

endmodule

/* src/stable_priority_queue.sv */
// Stable minimum priority queue, built as a sorted chain of cells.
// Input: an operation is taken at a rising edge where start is high and busy
// is low. kind selects insert (priority_req, item_key), peek or remove-next.
// busy is always low: every cell compares its entry against the new priority
// in parallel and shifts by one place, so one operation is taken per cycle.
// Output: one transaction per operation, shown for one cycle with done high,
// in the cycle after the operation is taken. The receiver cannot stall, so it
// must take each result in the cycle that done marks.
// Insert echoes key and priority; status full means the item was dropped.
// Peek and remove return the head (lowest priority number, earliest arrival
// among equals); status empty with zero key and priority when nothing is held.
// Kind code three does nothing and returns zero fields with status ok.
// Reset clears every valid bit at once: the queue starts empty and is ready
// in the first cycle after reset is released.
module stable_priority_queue
	import spq_pkg::*;
#(
	parameter int CAPACITY = 64,
	parameter int PRIORITY_BITS = 8,
	parameter int KEY_BITS = 16
) (
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic                     start,
	input  logic [1:0]               kind,
	input  logic [PRIORITY_BITS-1:0] priority_req,
	input  logic [KEY_BITS-1:0]      item_key,
	output logic                     busy,
	output logic                     done,
	output logic [KEY_BITS-1:0]      result_key,
	output logic [PRIORITY_BITS-1:0] result_priority,
	output logic [1:0]               status
);

	logic                     cell_keep  [CAPACITY];
	logic                     cell_valid [CAPACITY];
	logic [PRIORITY_BITS-1:0] cell_prio  [CAPACITY];
	logic [KEY_BITS-1:0]      cell_key   [CAPACITY];

	logic                     accept;
	logic                     full;
	logic                     empty;
	cell_ctl_t                ctl;
	logic                     done_q;
	logic [KEY_BITS-1:0]      rkey_d;
	logic [PRIORITY_BITS-1:0] rprio_d;
	logic [1:0]               status_d;
	logic [KEY_BITS-1:0]      rkey_q;
	logic [PRIORITY_BITS-1:0] rprio_q;
	logic [1:0]               status_q;

	assign busy   = 1'b0;
	assign accept = start && !busy;
	assign full   = cell_valid[CAPACITY-1];
	assign empty  = !cell_valid[0];

	assign ctl.ins = accept && (kind == KIND_INSERT) && !full;
	assign ctl.rem = accept && (kind == KIND_REMOVE) && !empty;

	for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
		logic                     l_keep;
		logic                     l_valid;
		logic [PRIORITY_BITS-1:0] l_prio;
		logic [KEY_BITS-1:0]      l_key;
		logic                     r_valid;
		logic [PRIORITY_BITS-1:0] r_prio;
		logic [KEY_BITS-1:0]      r_key;

		if (i == 0) begin : g_head
			assign l_keep  = 1'b1;
			assign l_valid = 1'b0;
			assign l_prio  = '0;
			assign l_key   = '0;
		end else begin : g_mid
			assign l_keep  = cell_keep[i-1];
			assign l_valid = cell_valid[i-1];
			assign l_prio  = cell_prio[i-1];
			assign l_key   = cell_key[i-1];
		end

		if (i == CAPACITY - 1) begin : g_tail
			assign r_valid = 1'b0;
			assign r_prio  = '0;
			assign r_key   = '0;
		end else begin : g_body
			assign r_valid = cell_valid[i+1];
			assign r_prio  = cell_prio[i+1];
			assign r_key   = cell_key[i+1];
		end

		spq_cell #(
			.PRIORITY_BITS(PRIORITY_BITS),
			.KEY_BITS     (KEY_BITS)
		) u_cell (
			.clk        (clk),
			.arst_n     (arst_n),
			.ctl        (ctl),
			.new_prio   (priority_req),
			.new_key    (item_key),
			.left_keep  (l_keep),
			.left_valid (l_valid),
			.left_prio  (l_prio),
			.left_key   (l_key),
			.right_valid(r_valid),
			.right_prio (r_prio),
			.right_key  (r_key),
			.keep       (cell_keep[i]),
			.valid      (cell_valid[i]),
			.prio       (cell_prio[i]),
			.key        (cell_key[i])
		);
	end

	always_comb begin
		rkey_d   = '0;
		rprio_d  = '0;
		status_d = ST_OK;
		case (kind)
			KIND_INSERT: begin
				rkey_d  = item_key;
				rprio_d = priority_req;
				if (full) begin
					status_d = ST_FULL;
				end
			end
			KIND_PEEK, KIND_REMOVE: begin
				if (empty) begin
					status_d = ST_EMPTY;
				end else begin
					rkey_d  = cell_key[0];
					rprio_d = cell_prio[0];
				end
			end
			default: begin
				status_d = ST_OK;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			done_q <= 1'b0;
		end else begin
			done_q <= accept;
		end
	end

	// Capture the result alongside the strobe
	always_ff @(posedge clk) begin
		if (accept) begin
			rkey_q   <= rkey_d;
			rprio_q  <= rprio_d;
			status_q <= status_d;
		end
	end

	assign done            = done_q;
	assign result_key      = rkey_q;
	assign result_priority = rprio_q;
	assign status          = status_q;

endmodule
